@@ sv/gpio_port_with_interrupt_detect_macros.svh @@
`ifndef GPIO_PORT_WITH_INTERRUPT_DETECT_MACROS_SVH
`define GPIO_PORT_WITH_INTERRUPT_DETECT_MACROS_SVH

// same-cycle implication, sampled on the rising edge
`define GPID_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("gpid assertion failed");

// next-cycle implication, sampled on the rising edge
`define GPID_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("gpid assertion failed");

`endif

@@ sv/gpid_pkg.sv @@
package gpid_pkg;

  localparam int DATA_W = 32;
  localparam int MODE_W = 2 * DATA_W;
  localparam int PIN_COUNT_DEFAULT = 32;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_DATA    = 3'd0,
    REG_DIR     = 3'd1,
    REG_PAD     = 3'd2,
    REG_ICFG_LO = 3'd3,
    REG_ICFG_HI = 3'd4,
    REG_MASK    = 3'd5,
    REG_STATUS  = 3'd6,
    REG_EDGESEL = 3'd7
  } reg_t;

  typedef enum logic [1:0] {
    MODE_LOW     = 2'd0,
    MODE_HIGH    = 2'd1,
    MODE_RISING  = 2'd2,
    MODE_FALLING = 2'd3
  } mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pad_out;
    logic [DATA_W-1:0] pad_drive_enable;
    logic              irq;
  } result_t;

endpackage

@@ sv/gpio_port_with_interrupt_detect.sv @@
// An accepted transaction's result is registered and appears on the output register in the next cycle.
// Throughput: one transaction per cycle; all pins are evaluated at once by one lane per pin.
// in_ready is low only while a result waits and out_ready is low.
// Reset (rst, synchronous): control and status registers, the previous pad sample and the
// output valid clear to zero, not the held result; every pin is an input in low-level mode.
module gpio_port_with_interrupt_detect #(
  parameter int PIN_COUNT = gpid_pkg::PIN_COUNT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  cmd,
  input  logic [2:0]                  reg_sel,
  input  logic [gpid_pkg::DATA_W-1:0] write_data,
  input  logic [gpid_pkg::DATA_W-1:0] pad_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gpid_pkg::DATA_W-1:0] read_data,
  output logic [gpid_pkg::DATA_W-1:0] pad_out,
  output logic [gpid_pkg::DATA_W-1:0] pad_drive_enable,
  output logic                        irq
);

  localparam logic [gpid_pkg::DATA_W-1:0] PinMask =
    {gpid_pkg::DATA_W{1'b1}} >> (gpid_pkg::DATA_W - PIN_COUNT);
  localparam logic [gpid_pkg::MODE_W-1:0] ModeMask =
    {gpid_pkg::MODE_W{1'b1}} >> (gpid_pkg::MODE_W - 2 * PIN_COUNT);

  logic [gpid_pkg::DATA_W-1:0] out_latch,   out_latch_next;
  logic [gpid_pkg::DATA_W-1:0] pin_dir,     pin_dir_next;
  logic [gpid_pkg::MODE_W-1:0] mode_bits,   mode_bits_next;
  logic [gpid_pkg::DATA_W-1:0] int_mask,    int_mask_next;
  logic [gpid_pkg::DATA_W-1:0] pending,     pending_next;
  logic [gpid_pkg::DATA_W-1:0] both_mask,   both_mask_next;
  logic [gpid_pkg::DATA_W-1:0] last_pad,    last_pad_next;
  logic [gpid_pkg::DATA_W-1:0] rd_next;
  logic [gpid_pkg::DATA_W-1:0] pad_now;
  logic [gpid_pkg::DATA_W-1:0] wd_masked;
  logic [gpid_pkg::DATA_W-1:0] hits;
  logic                        fire;
  gpid_pkg::result_t           result;
  gpid_pkg::result_t           held;

  assign pad_now   = pad_sample & PinMask;
  assign wd_masked = write_data & PinMask;
  assign fire      = in_valid & in_ready;

  for (genvar p = 0; p < gpid_pkg::DATA_W; p++) begin : g_lane
    if (p < PIN_COUNT) begin : g_pin
      gpid_lane u_lane (
        .cur  (pad_now[p]),
        .prev (last_pad[p]),
        .both (both_mask[p]),
        .mode (gpid_pkg::mode_t'(mode_bits[2*p +: 2])),
        .hit  (hits[p])
      );
    end else begin : g_none
      assign hits[p] = 1'b0;
    end
  end

  always_comb begin
    out_latch_next = out_latch;
    pin_dir_next   = pin_dir;
    mode_bits_next = mode_bits;
    int_mask_next  = int_mask;
    pending_next   = pending;
    both_mask_next = both_mask;
    last_pad_next  = last_pad;
    rd_next        = '0;
    case (gpid_pkg::cmd_t'(cmd))
      gpid_pkg::CMD_WRITE: begin
        case (gpid_pkg::reg_t'(reg_sel))
          gpid_pkg::REG_DATA:    out_latch_next = wd_masked;
          gpid_pkg::REG_DIR:     pin_dir_next   = wd_masked;
          gpid_pkg::REG_PAD:     ;
          gpid_pkg::REG_ICFG_LO: begin
            mode_bits_next = {mode_bits[gpid_pkg::MODE_W-1:gpid_pkg::DATA_W], write_data}
                             & ModeMask;
          end
          gpid_pkg::REG_ICFG_HI: begin
            mode_bits_next = {write_data, mode_bits[gpid_pkg::DATA_W-1:0]} & ModeMask;
          end
          gpid_pkg::REG_MASK:    int_mask_next  = wd_masked;
          gpid_pkg::REG_STATUS:  pending_next   = pending & ~wd_masked;
          gpid_pkg::REG_EDGESEL: both_mask_next = wd_masked;
          default:               ;
        endcase
      end
      gpid_pkg::CMD_READ: begin
        case (gpid_pkg::reg_t'(reg_sel))
          gpid_pkg::REG_DATA:    rd_next = (out_latch & pin_dir) | (last_pad & ~pin_dir);
          gpid_pkg::REG_DIR:     rd_next = pin_dir;
          gpid_pkg::REG_PAD:     rd_next = last_pad;
          gpid_pkg::REG_ICFG_LO: rd_next = mode_bits[gpid_pkg::DATA_W-1:0];
          gpid_pkg::REG_ICFG_HI: rd_next = mode_bits[gpid_pkg::MODE_W-1:gpid_pkg::DATA_W];
          gpid_pkg::REG_MASK:    rd_next = int_mask;
          gpid_pkg::REG_STATUS:  rd_next = pending;
          gpid_pkg::REG_EDGESEL: rd_next = both_mask;
          default:               rd_next = '0;
        endcase
      end
      gpid_pkg::CMD_TICK: begin
        pending_next  = pending | hits;
        last_pad_next = pad_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_latch <= '0;
      pin_dir   <= '0;
      mode_bits <= '0;
      int_mask  <= '0;
      pending   <= '0;
      both_mask <= '0;
      last_pad  <= '0;
    end else if (fire) begin
      out_latch <= out_latch_next;
      pin_dir   <= pin_dir_next;
      mode_bits <= mode_bits_next;
      int_mask  <= int_mask_next;
      pending   <= pending_next;
      both_mask <= both_mask_next;
      last_pad  <= last_pad_next;
    end
  end

  assign result.read_data        = rd_next;
  assign result.pad_out          = out_latch_next;
  assign result.pad_drive_enable = pin_dir_next;
  assign result.irq              = |(pending_next & int_mask_next);

  gpid_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (in_valid),
    .result (result),
    .take   (in_ready),
    .valid  (out_valid),
    .ready  (out_ready),
    .held   (held)
  );

  assign read_data        = held.read_data;
  assign pad_out          = held.pad_out;
  assign pad_drive_enable = held.pad_drive_enable;
  assign irq              = held.irq;

endmodule

@@ sv/gpid_lane.sv @@
module gpid_lane (
  input  logic            cur,
  input  logic            prev,
  input  logic            both,
  input  gpid_pkg::mode_t mode,
  output logic            hit
);

  always_comb begin
    if (both) begin
      hit = cur ^ prev;
    end else begin
      case (mode)
        gpid_pkg::MODE_LOW:     hit = ~cur;
        gpid_pkg::MODE_HIGH:    hit = cur;
        gpid_pkg::MODE_RISING:  hit = ~prev & cur;
        gpid_pkg::MODE_FALLING: hit = prev & ~cur;
        default:                hit = 1'b0;
      endcase
    end
  end

endmodule

@@ sv/gpid_out_stage.sv @@
module gpid_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  gpid_pkg::result_t result,
  output logic              take,
  output logic              valid,
  input  logic              ready,
  output gpid_pkg::result_t held
);

  logic valid_next;

  assign take       = ~valid | ready;
  assign valid_next = (load & take) | (valid & ~ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && take) begin
      held <= result;
    end
  end

endmodule

@@ sv/gpid_checker.sv @@
`include "gpio_port_with_interrupt_detect_macros.svh"

module gpid_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  cmd,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gpid_pkg::DATA_W-1:0] read_data,
  input logic [gpid_pkg::DATA_W-1:0] pad_out,
  input logic [gpid_pkg::DATA_W-1:0] pad_drive_enable,
  input logic                        irq
);

  logic                        fire;
  logic                        fire_other;
  logic [3*gpid_pkg::DATA_W:0] out_word;

  assign fire       = in_valid & in_ready;
  assign fire_other = fire & (cmd != gpid_pkg::CMD_READ);
  assign out_word   = {read_data, pad_out, pad_drive_enable, irq};

  `GPID_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))
  `GPID_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)
  `GPID_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `GPID_ASSERT_NEXT(a_accept_gives_result, clk, rst, fire, out_valid)
  `GPID_ASSERT_NEXT(a_read_data_only_on_read, clk, rst, fire_other, read_data == '0)

endmodule

bind gpio_port_with_interrupt_detect gpid_checker u_gpid_checker (.*);

@@ dv/gpio_port_with_interrupt_detect_tb.sv @@
`timescale 1ns / 100ps

module gpio_port_with_interrupt_detect_tb;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [31:0] PIN_MASK =
    32'hFFFF_FFFF >> (32 - gpid_pkg::PIN_COUNT_DEFAULT);
  localparam logic [63:0] MODE_MASK =
    64'hFFFF_FFFF_FFFF_FFFF >> (64 - 2 * gpid_pkg::PIN_COUNT_DEFAULT);
  localparam int RAND_ITEMS = 850;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] latch;
    logic [31:0] dir;
    logic [63:0] modes;
    logic [31:0] mask;
    logic [31:0] pend;
    logic [31:0] both;
    logic [31:0] prev;
  } port_state_t;

  typedef struct {
    logic [1:0]        op;
    logic [2:0]        sel;
    logic [31:0]       wd;
    logic [31:0]       pad;
    bit                chk;
    gpid_pkg::result_t want;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [2:0]  reg_sel = '0;
  logic [31:0] write_data = '0;
  logic [31:0] pad_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic [31:0] pad_out;
  logic [31:0] pad_drive_enable;
  logic        irq;

  port_state_t       shadow;
  gpid_pkg::result_t due_results[$];
  stim_t             directed[$];
  logic [31:0]       last_pad = '0;
  bit                calm = 1'b0;
  int                hold_left = 0;
  int                cycle_cnt = 0;
  int                fail_cnt = 0;
  int                n_write = 0;
  int                n_read = 0;
  int                n_tick = 0;
  int                n_none = 0;
  int                n_checked = 0;
  int                n_irq = 0;

  gpio_port_with_interrupt_detect i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .reg_sel          (reg_sel),
    .write_data       (write_data),
    .pad_sample       (pad_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .read_data        (read_data),
    .pad_out          (pad_out),
    .pad_drive_enable (pad_drive_enable),
    .irq              (irq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] irq_hits(input logic [31:0] now);
    logic [31:0] hits;
    logic [1:0]  md;
    hits = '0;
    for (int p = 0; p < 32; p++) begin
      md = shadow.modes[2*p +: 2];
      if (shadow.both[p]) begin
        hits[p] = now[p] != shadow.prev[p];
      end else begin
        case (md)
          gpid_pkg::MODE_LOW:    hits[p] = !now[p];
          gpid_pkg::MODE_HIGH:   hits[p] = now[p];
          gpid_pkg::MODE_RISING: hits[p] = !shadow.prev[p] && now[p];
          default:               hits[p] = shadow.prev[p] && !now[p];
        endcase
      end
    end
    return hits & PIN_MASK;
  endfunction

  task automatic advance_port(input stim_t it, output gpid_pkg::result_t r);
    logic [31:0] m;
    logic [31:0] rd;
    m = it.wd & PIN_MASK;
    rd = '0;
    if (it.op == gpid_pkg::CMD_WRITE) begin
      case (it.sel)
        gpid_pkg::REG_DATA:    shadow.latch = m;
        gpid_pkg::REG_DIR:     shadow.dir = m;
        gpid_pkg::REG_PAD:     ;
        gpid_pkg::REG_ICFG_LO: shadow.modes = {shadow.modes[63:32], it.wd} & MODE_MASK;
        gpid_pkg::REG_ICFG_HI: shadow.modes = {it.wd, shadow.modes[31:0]} & MODE_MASK;
        gpid_pkg::REG_MASK:    shadow.mask = m;
        gpid_pkg::REG_STATUS:  shadow.pend = shadow.pend & ~m;
        default:               shadow.both = m;
      endcase
    end else if (it.op == gpid_pkg::CMD_READ) begin
      case (it.sel)
        gpid_pkg::REG_DATA:    rd = (shadow.latch & shadow.dir) | (shadow.prev & ~shadow.dir);
        gpid_pkg::REG_DIR:     rd = shadow.dir;
        gpid_pkg::REG_PAD:     rd = shadow.prev;
        gpid_pkg::REG_ICFG_LO: rd = shadow.modes[31:0];
        gpid_pkg::REG_ICFG_HI: rd = shadow.modes[63:32];
        gpid_pkg::REG_MASK:    rd = shadow.mask;
        gpid_pkg::REG_STATUS:  rd = shadow.pend;
        default:               rd = shadow.both;
      endcase
    end else if (it.op == gpid_pkg::CMD_TICK) begin
      shadow.pend = shadow.pend | irq_hits(it.pad & PIN_MASK);
      shadow.prev = it.pad & PIN_MASK;
    end
    r.read_data = rd;
    r.pad_out = shadow.latch;
    r.pad_drive_enable = shadow.dir;
    r.irq = |(shadow.pend & shadow.mask);
  endtask

  function automatic stim_t row(input logic [1:0] op, input logic [2:0] sel,
                                input logic [31:0] wd = '0, input logic [31:0] pad = '0,
                                input bit chk = 1'b0, input logic [31:0] rd = '0,
                                input logic [31:0] po = '0, input logic [31:0] oe = '0,
                                input logic ir = 1'b0);
    stim_t s;
    s.op = op;
    s.sel = sel;
    s.wd = wd;
    s.pad = pad;
    s.chk = chk;
    s.want.read_data = rd;
    s.want.pad_out = po;
    s.want.pad_drive_enable = oe;
    s.want.irq = ir;
    return s;
  endfunction

  function automatic stim_t next_stim();
    stim_t s;
    int k;
    s = row(CMD_NONE, 3'($urandom_range(0, 7)), $urandom(), $urandom());
    k = $urandom_range(0, 99);
    if (k < 4) begin
      s.op = CMD_NONE;
    end else if (k < 38) begin
      s.op = gpid_pkg::CMD_TICK;
      case ($urandom_range(0, 9))
        0:       s.pad = '0;
        1:       s.pad = '1;
        2, 3, 4: s.pad = $urandom();
        default: s.pad = last_pad ^ (32'h1 << $urandom_range(0, 31))
                         ^ ($urandom() & $urandom() & $urandom());
      endcase
      last_pad = s.pad;
    end else if (k < 68) begin
      s.op = gpid_pkg::CMD_WRITE;
      case (s.sel)
        gpid_pkg::REG_ICFG_LO, gpid_pkg::REG_ICFG_HI:
          if ($urandom_range(0, 1) == 0) s.wd = {16{2'($urandom_range(0, 3))}};
        gpid_pkg::REG_STATUS:
          if ($urandom_range(0, 2) == 0) s.wd = '1;
        gpid_pkg::REG_MASK:
          if ($urandom_range(0, 3) == 0) s.wd = '1;
        gpid_pkg::REG_EDGESEL:
          if ($urandom_range(0, 1) == 0) s.wd = $urandom() & $urandom();
        default: ;
      endcase
    end else begin
      s.op = gpid_pkg::CMD_READ;
    end
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  task automatic send_item(input stim_t it, input int gap);
    gpid_pkg::result_t r;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd <= it.op;
    reg_sel <= it.sel;
    write_data <= it.wd;
    pad_sample <= it.pad;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    advance_port(it, r);
    due_results.push_back(it.chk ? it.want : r);
    case (it.op)
      gpid_pkg::CMD_WRITE: n_write++;
      gpid_pkg::CMD_READ:  n_read++;
      gpid_pkg::CMD_TICK:  n_tick++;
      default:             n_none++;
    endcase
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
      hold_left = $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b0;
      hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    gpid_pkg::result_t want;
    bit bad;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result at cycle %0d: read_data %h", cycle_cnt, read_data);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (irq === 1'b1) n_irq++;
        bad = (read_data !== want.read_data) || (pad_out !== want.pad_out)
              || (pad_drive_enable !== want.pad_drive_enable) || (irq !== want.irq);
        if (bad) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch on result %0d: read_data %h/%h pad_out %h/%h oe %h/%h irq %b/%b",
                     n_checked, want.read_data, read_data, want.pad_out, pad_out,
                     want.pad_drive_enable, pad_drive_enable, want.irq, irq);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_t it;
    int n;
    shadow = '{default: '0};
    // reset values, read-only pad register, then first tick and edge handling
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_DATA, '0, '0, 1'b1));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_PAD, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_PAD, '0, '0, 1'b1));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_DIR, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_DATA, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_DATA, '0, '0, 1'b1,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_DIR, 32'h0000_FFFF));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_MASK, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_ICFG_LO, 32'hAAAA_AAAA));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_ICFG_HI, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_TICK,  gpid_pkg::REG_DATA, '0, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_STATUS));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_STATUS, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_TICK,  gpid_pkg::REG_DATA, '0, 32'h0000_0000));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_EDGESEL, 32'h0000_FFFF));
    directed.push_back(row(gpid_pkg::CMD_TICK,  gpid_pkg::REG_DATA, '0, 32'h5555_AAAA));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_EDGESEL));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_ICFG_LO));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_ICFG_HI));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_ICFG_HI, 32'h5555_5555));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_ICFG_LO, 32'h0000_0000));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_STATUS, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_TICK,  gpid_pkg::REG_DATA, '0, 32'h1234_5678));
    directed.push_back(row(gpid_pkg::CMD_TICK,  gpid_pkg::REG_DATA, '0, 32'h1234_5678));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_DATA));
    directed.push_back(row(CMD_NONE, gpid_pkg::REG_STATUS, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(row(gpid_pkg::CMD_READ,  gpid_pkg::REG_STATUS));
    directed.push_back(row(gpid_pkg::CMD_WRITE, gpid_pkg::REG_MASK, 32'h0000_0000));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i], pick_gap());
    last_pad = shadow.prev;

    n = 0;
    while (n < RAND_ITEMS) begin
      calm = ((n / 120) % 3) == 1;
      it = next_stim();
      if (it.op != CMD_NONE
          && !(it.op == gpid_pkg::CMD_WRITE && it.sel == gpid_pkg::REG_PAD)) n++;
      send_item(it, pick_gap());
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d transactions: %0d writes, %0d reads, %0d pad ticks, %0d unused.",
             n_write + n_read + n_tick + n_none, n_write, n_read, n_tick, n_none);
    $display("Checked %0d results, irq raised in %0d, %0d failures.",
             n_checked, n_irq, fail_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
